// ===== rtl/abbc_pkg.sv =====
`timescale 1ns / 1ps
// Package with the shared types, register indexes and the microcode program of the biquad chain.
package abbc_pkg;

  localparam int COEF_W    = 16;
  localparam int SAMP_W    = 32;
  localparam int OUT_W     = 16;
  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_HP_FEED  = 3'd0;
  localparam cfg_idx_t REG_HP_BACK1 = 3'd1;
  localparam cfg_idx_t REG_HP_BACK2 = 3'd2;
  localparam cfg_idx_t REG_BP_FEED  = 3'd3;
  localparam cfg_idx_t REG_BP_BACK1 = 3'd4;
  localparam cfg_idx_t REG_BP_BACK2 = 3'd5;

  localparam logic signed [COEF_W-1:0] RST_HP_FEED  = 16'sd15935;
  localparam logic signed [COEF_W-1:0] RST_HP_BACK1 = -16'sd31859;
  localparam logic signed [COEF_W-1:0] RST_HP_BACK2 = 16'sd15499;
  localparam logic signed [COEF_W-1:0] RST_BP_FEED  = 16'sd6729;
  localparam logic signed [COEF_W-1:0] RST_BP_BACK1 = -16'sd17595;
  localparam logic signed [COEF_W-1:0] RST_BP_BACK2 = 16'sd2926;

  typedef logic [3:0] pc_t;

  localparam pc_t PC_IDLE   = 4'd0;
  localparam pc_t PC_FINISH = 4'd10;

  // Operand that the shared multiplier sees next to the selected coefficient.
  typedef enum logic [2:0] {
    DSEL_HP_DIFF,
    DSEL_HP_Y1,
    DSEL_HP_Y2,
    DSEL_BP_DIFF,
    DSEL_BP_Y1,
    DSEL_BP_Y2
  } dsel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_WAIT_OUT,
    JMP_GOTO
  } jmp_t;

  typedef struct packed {
    jmp_t     jmp;
    pc_t      target;
    cfg_idx_t coef;
    dsel_t    dsel;
    acc_op_t  acc_op;
    logic     hp_wr;
  } uword_t;

  // The program. The product of a step is accumulated in the step after it.
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    w = '{jmp: JMP_NEXT, target: PC_IDLE, coef: REG_HP_FEED, dsel: DSEL_HP_DIFF,
          acc_op: ACC_HOLD, hp_wr: 1'b0};
    case (pc)
      4'd0: begin
        w.jmp = JMP_WAIT_IN;
      end
      4'd1: begin
        w.coef = REG_HP_FEED;
        w.dsel = DSEL_HP_DIFF;
      end
      4'd2: begin
        w.coef   = REG_HP_BACK1;
        w.dsel   = DSEL_HP_Y1;
        w.acc_op = ACC_LOAD;
      end
      4'd3: begin
        w.coef   = REG_HP_BACK2;
        w.dsel   = DSEL_HP_Y2;
        w.acc_op = ACC_SUB;
      end
      4'd4: begin
        w.acc_op = ACC_SUB;
      end
      4'd5: begin
        w.hp_wr = 1'b1;
      end
      4'd6: begin
        w.coef = REG_BP_FEED;
        w.dsel = DSEL_BP_DIFF;
      end
      4'd7: begin
        w.coef   = REG_BP_BACK1;
        w.dsel   = DSEL_BP_Y1;
        w.acc_op = ACC_LOAD;
      end
      4'd8: begin
        w.coef   = REG_BP_BACK2;
        w.dsel   = DSEL_BP_Y2;
        w.acc_op = ACC_SUB;
      end
      4'd9: begin
        w.acc_op = ACC_SUB;
      end
      4'd10: begin
        w.jmp    = JMP_WAIT_OUT;
        w.target = PC_IDLE;
      end
      default: begin
        w.jmp    = JMP_GOTO;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/abbc_in_if.sv =====
`timescale 1ns / 1ps
// Input channel interface carrying one converter code per transaction.
interface abbc_in_if #(
  parameter int ADC_BITS = 12
) ();
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink (input valid, input adc_code, output ready);
endinterface

// ===== rtl/abbc_out_if.sv =====
`timescale 1ns / 1ps
// Result channel interface carrying one filtered sample per transaction.
interface abbc_out_if
  import abbc_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] filtered_sample;

  modport source (output valid, output filtered_sample, input ready);
  modport sink (input valid, input filtered_sample, output ready);
endinterface

// ===== rtl/abbc_mac.sv =====
`timescale 1ns / 1ps
// Shared multiply-accumulate unit with rounding, scaling and 32-bit saturation.
module abbc_mac
  import abbc_pkg::*;
#(
  parameter int OPW            = 33,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                     clk,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [OPW-1:0]    operand,
  input  acc_op_t                  acc_op,
  output logic signed [SAMP_W-1:0] scaled
);

  localparam int PRODW = COEF_W + OPW;
  localparam int ACCW  = PRODW + 2;
  localparam logic signed [ACCW-1:0] HALF =
    {{(ACCW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

  logic signed [PRODW-1:0] prod_r;
  logic signed [ACCW-1:0]  acc_r;
  logic signed [ACCW-1:0]  rnd;
  logic signed [ACCW-1:0]  shifted;
  logic [ACCW-SAMP_W:0]    upper;

  always_ff @(posedge clk) begin
    prod_r <= coef * operand;
    case (acc_op)
      ACC_LOAD: acc_r <= ACCW'(prod_r);
      ACC_SUB:  acc_r <= acc_r - ACCW'(prod_r);
      default:  acc_r <= acc_r;
    endcase
  end

  // Round half up, then floor shift.
  assign rnd     = acc_r + HALF;
  assign shifted = rnd >>> COEF_FRAC_BITS;
  assign upper   = shifted[ACCW-1:SAMP_W-1];

  always_comb begin
    if ((&upper) || !(|upper)) begin
      scaled = shifted[SAMP_W-1:0];
    end else begin
      scaled = {shifted[ACCW-1], {(SAMP_W-1){~shifted[ACCW-1]}}};
    end
  end

endmodule

// ===== rtl/adc_highpass_bandpass_biquad_chain.sv =====
`timescale 1ns / 1ps
// Each accepted input runs the whole microcode program, which puts all six products of
// both biquads through one shared multiplier and accumulator; no new input is taken
// until the program has finished and returned to its idle step.
// A new input is taken while the previous result still waits on the output register.
// Reset (rst_n, synchronous, active low) restores the coefficients and clears all history.
module adc_highpass_bandpass_biquad_chain
  import abbc_pkg::*;
#(
  parameter int ADC_BITS         = 12,
  parameter int COEF_FRAC_BITS   = 14,
  parameter int SAMPLE_FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  abbc_in_if.sink           in_chan,
  abbc_out_if.source        out_chan,
  input  logic              cfg_wr_en,
  input  cfg_idx_t          cfg_index,
  input  logic [COEF_W-1:0] cfg_data
);

  // The feed-forward term of the high-pass stage, x0 - 2*x1 + x2, needs 18 bits
  // before it is scaled to the sample format; the band-pass difference needs 33.
  localparam int DIFFW = 19 + SAMPLE_FRAC_BITS;
  localparam int OPW   = (DIFFW > SAMP_W + 1) ? DIFFW : SAMP_W + 1;
  localparam logic [ADC_BITS-1:0] ADC_MID = {1'b1, {(ADC_BITS-1){1'b0}}};
  localparam logic signed [SAMP_W:0] OUT_MAX = 33'sd32767;
  localparam logic signed [SAMP_W:0] OUT_MIN = -33'sd32768;

  // Sequencer and coefficient registers.
  pc_t    pc_r, pc_nxt;
  uword_t uw;

  logic signed [COEF_W-1:0] hp_feed_r, hp_back1_r, hp_back2_r;
  logic signed [COEF_W-1:0] bp_feed_r, bp_back1_r, bp_back2_r;

  // Sample history. The high-pass output history doubles as the band-pass input history.
  logic signed [15:0]       x0_r, hx1_r, hx2_r;
  logic signed [SAMP_W-1:0] hp_r, hy1_r, hy2_r, by1_r, by2_r;

  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_sample_r;

  logic                     in_fire;
  logic                     slot_free;
  logic [ADC_BITS-1:0]      code_diff;
  logic [15:0]              centred;
  logic signed [COEF_W-1:0] coef_sel;
  logic signed [OPW-1:0]    operand;
  logic signed [SAMP_W-1:0] scaled;
  logic signed [SAMP_W:0]   bp_ext, bp_mag, bp_qmag, bp_q;
  logic signed [OUT_W-1:0]  out_sat;

  assign uw = ucode(pc_r);

  // No input is taken while reset is held.
  assign in_chan.ready = (uw.jmp == JMP_WAIT_IN) && rst_n;
  assign in_fire       = in_chan.valid && in_chan.ready;
  // The finishing step may write the output register once it is empty or being drained.
  assign slot_free     = !out_valid_r || out_chan.ready;

  assign out_chan.valid           = out_valid_r;
  assign out_chan.filtered_sample = out_sample_r;

  // Centring wraps modulo 2^16, which is why code zero lands on the most negative value.
  assign code_diff = ADC_MID - in_chan.adc_code;
  assign centred   = 16'(code_diff) << (16 - ADC_BITS);

  always_comb begin
    case (uw.coef)
      REG_HP_FEED:  coef_sel = hp_feed_r;
      REG_HP_BACK1: coef_sel = hp_back1_r;
      REG_HP_BACK2: coef_sel = hp_back2_r;
      REG_BP_FEED:  coef_sel = bp_feed_r;
      REG_BP_BACK1: coef_sel = bp_back1_r;
      REG_BP_BACK2: coef_sel = bp_back2_r;
      default:      coef_sel = hp_feed_r;
    endcase
  end

  // Because b2 = b0 and b1 = -2*b0 in the high-pass stage, and b1 = 0, b2 = -b0 in the
  // band-pass stage, each stage folds its feed-forward taps into one product.
  always_comb begin
    case (uw.dsel)
      DSEL_HP_DIFF: operand = (OPW'(x0_r) - (OPW'(hx1_r) <<< 1) + OPW'(hx2_r))
                              <<< SAMPLE_FRAC_BITS;
      DSEL_HP_Y1:   operand = OPW'(hy1_r);
      DSEL_HP_Y2:   operand = OPW'(hy2_r);
      DSEL_BP_DIFF: operand = OPW'(hp_r) - OPW'(hy2_r);
      DSEL_BP_Y1:   operand = OPW'(by1_r);
      DSEL_BP_Y2:   operand = OPW'(by2_r);
      default:      operand = '0;
    endcase
  end

  abbc_mac #(
    .OPW            (OPW),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk     (clk),
    .coef    (coef_sel),
    .operand (operand),
    .acc_op  (uw.acc_op),
    .scaled  (scaled)
  );

  // In the finishing step the scaled accumulator holds the band-pass result. The
  // output drops the fraction bits toward zero and saturates to 16 bits.
  assign bp_ext  = (SAMP_W + 1)'(scaled);
  assign bp_mag  = bp_ext[SAMP_W] ? -bp_ext : bp_ext;
  assign bp_qmag = bp_mag >>> SAMPLE_FRAC_BITS;
  assign bp_q    = bp_ext[SAMP_W] ? -bp_qmag : bp_qmag;

  always_comb begin
    if (bp_q > OUT_MAX) begin
      out_sat = OUT_MAX[OUT_W-1:0];
    end else if (bp_q < OUT_MIN) begin
      out_sat = OUT_MIN[OUT_W-1:0];
    end else begin
      out_sat = bp_q[OUT_W-1:0];
    end
  end

  always_comb begin
    case (uw.jmp)
      JMP_NEXT:     pc_nxt = pc_r + 4'd1;
      JMP_WAIT_IN:  pc_nxt = in_fire ? pc_r + 4'd1 : pc_r;
      JMP_WAIT_OUT: pc_nxt = slot_free ? uw.target : pc_r;
      JMP_GOTO:     pc_nxt = uw.target;
      default:      pc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      out_valid_r <= 1'b0;
      hp_feed_r   <= RST_HP_FEED;
      hp_back1_r  <= RST_HP_BACK1;
      hp_back2_r  <= RST_HP_BACK2;
      bp_feed_r   <= RST_BP_FEED;
      bp_back1_r  <= RST_BP_BACK1;
      bp_back2_r  <= RST_BP_BACK2;
      hx1_r       <= '0;
      hx2_r       <= '0;
      hy1_r       <= '0;
      hy2_r       <= '0;
      by1_r       <= '0;
      by2_r       <= '0;
    end else begin
      pc_r <= pc_nxt;

      if (cfg_wr_en) begin
        case (cfg_index)
          REG_HP_FEED:  hp_feed_r  <= cfg_data;
          REG_HP_BACK1: hp_back1_r <= cfg_data;
          REG_HP_BACK2: hp_back2_r <= cfg_data;
          REG_BP_FEED:  bp_feed_r  <= cfg_data;
          REG_BP_BACK1: bp_back1_r <= cfg_data;
          REG_BP_BACK2: bp_back2_r <= cfg_data;
          default: ;
        endcase
      end

      if (uw.jmp == JMP_WAIT_OUT && slot_free) begin
        // Commit the sample: shift all histories and load the output register.
        hx1_r        <= x0_r;
        hx2_r        <= hx1_r;
        hy1_r        <= hp_r;
        hy2_r        <= hy1_r;
        by1_r        <= scaled;
        by2_r        <= by1_r;
        out_valid_r  <= 1'b1;
        out_sample_r <= out_sat;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x0_r <= centred;
    end
    if (uw.hp_wr) begin
      hp_r <= scaled;
    end
  end

  // An accepted input always starts the program at its first working step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (pc_r == 4'd1))
    else $error("sequencer did not start after an input transaction");

  // A result only appears right after the finishing step.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(pc_r) == PC_FINISH))
    else $error("output became valid outside the finishing step");

  // The step counter never leaves the program.
  assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r <= PC_FINISH))
    else $error("step counter ran past the end of the program");

  // The captured input holds for the whole run of the program.
  assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r > 4'd1) |-> $stable(x0_r))
    else $error("input sample changed while the program was running");

endmodule

// ===== tb/adc_highpass_bandpass_biquad_chain_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the two-stage high-pass / band-pass biquad chain.
module adc_highpass_bandpass_biquad_chain_tb;
  import abbc_pkg::*;

  localparam int ADC_BITS         = 12;
  localparam int COEF_FRAC_BITS   = 14;
  localparam int SAMPLE_FRAC_BITS = 8;
  localparam int NUM_COEFS        = 6;

  // The converter midpoint and the shift that brings a code up to 16 bits.
  localparam int MID_CODE    = 1 << (ADC_BITS - 1);
  localparam int CODE_MAX    = (1 << ADC_BITS) - 1;
  localparam int CODE_LSHIFT = 16 - ADC_BITS;

  localparam longint SAMPLE_ONE = longint'(1) <<< SAMPLE_FRAC_BITS;
  localparam longint ROUND_HALF = longint'(1) <<< (COEF_FRAC_BITS - 1);
  localparam longint S32_MAX    = 64'sd2147483647;
  localparam longint S32_MIN    = -64'sd2147483648;
  localparam longint OUT_MAX    = 64'sd32767;
  localparam longint OUT_MIN    = -64'sd32768;

  // Register indexes past the last coefficient; writes there must be ignored.
  localparam cfg_idx_t IDX_SPARE_LO = REG_BP_BACK2 + 3'd1;
  localparam cfg_idx_t IDX_SPARE_HI = '1;

  localparam int CLK_HALF_NS     = 5;
  localparam int RESET_CYCLES    = 9;
  localparam int DRAIN_CYCLES    = 16;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int REPORT_LIMIT    = 10;
  localparam int TIMEOUT_NS      = 5_000_000;

  typedef enum int {
    RECV_STEADY,
    RECV_RANDOM,
    RECV_PATTERN
  } recv_style_t;

  typedef enum int {
    SEG_NOISE,
    SEG_SQUARE,
    SEG_TRIANGLE,
    SEG_HOLD,
    SEG_HUM
  } seg_kind_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_wr_en = 1'b0;
  cfg_idx_t cfg_index = REG_HP_FEED;
  logic [COEF_W-1:0] cfg_data = '0;

  abbc_in_if #(.ADC_BITS(ADC_BITS)) in_chan ();
  abbc_out_if out_chan ();

  adc_highpass_bandpass_biquad_chain #(
    .ADC_BITS        (ADC_BITS),
    .COEF_FRAC_BITS  (COEF_FRAC_BITS),
    .SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Filter predictor. It keeps its own copy of the coefficients and of the
  // sample history, and advances the history once per accepted input transaction.
  // ---------------------------------------------------------------------------
  logic signed [COEF_W-1:0] coef [NUM_COEFS] = '{RST_HP_FEED, RST_HP_BACK1, RST_HP_BACK2,
                                                 RST_BP_FEED, RST_BP_BACK1, RST_BP_BACK2};
  logic signed [15:0]       centred_hist [2] = '{16'sd0, 16'sd0};
  logic signed [SAMP_W-1:0] hp_hist [2] = '{32'sd0, 32'sd0};
  logic signed [SAMP_W-1:0] bp_hist [2] = '{32'sd0, 32'sd0};

  int stage_clip_count = 0;
  int output_clip_count = 0;

  // Rounds a Q14 sum of products half up and clips it to a 32-bit sample.
  function automatic logic signed [SAMP_W-1:0] round_to_sample(input longint sum);
    longint scaled;
    scaled = (sum + ROUND_HALF) >>> COEF_FRAC_BITS;
    if (scaled > S32_MAX) begin
      stage_clip_count++;
      return 32'sh7fff_ffff;
    end
    if (scaled < S32_MIN) begin
      stage_clip_count++;
      return 32'sh8000_0000;
    end
    return scaled[SAMP_W-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] predict_filtered_sample(
    input logic [ADC_BITS-1:0] code
  );
    logic [15:0]              centred;
    logic signed [15:0]       x0;
    logic signed [SAMP_W-1:0] hp;
    logic signed [SAMP_W-1:0] bp;
    longint                   sum;
    longint                   wide;
    longint                   q;
    // Centring wraps in 16 bits, which is why code zero lands on -32768.
    centred = 16'(MID_CODE) - {{(16 - ADC_BITS){1'b0}}, code};
    centred = centred << CODE_LSHIFT;
    x0 = signed'(centred);

    sum = longint'(coef[REG_HP_FEED]) * ((longint'(x0) - 2 * longint'(centred_hist[0])
          + longint'(centred_hist[1])) * SAMPLE_ONE);
    sum -= longint'(coef[REG_HP_BACK1]) * longint'(hp_hist[0]);
    sum -= longint'(coef[REG_HP_BACK2]) * longint'(hp_hist[1]);
    hp = round_to_sample(sum);

    // The band-pass input history is the high-pass output history.
    sum = longint'(coef[REG_BP_FEED]) * (longint'(hp) - longint'(hp_hist[1]));
    sum -= longint'(coef[REG_BP_BACK1]) * longint'(bp_hist[0]);
    sum -= longint'(coef[REG_BP_BACK2]) * longint'(bp_hist[1]);
    bp = round_to_sample(sum);

    centred_hist[1] = centred_hist[0];
    centred_hist[0] = x0;
    hp_hist[1] = hp_hist[0];
    hp_hist[0] = hp;
    bp_hist[1] = bp_hist[0];
    bp_hist[0] = bp;

    // Drop the fraction bits toward zero, then clip to int16.
    wide = bp;
    if (wide >= 0) begin
      q = wide >>> SAMPLE_FRAC_BITS;
    end else begin
      q = -((-wide) >>> SAMPLE_FRAC_BITS);
    end
    if (q > OUT_MAX) begin
      q = OUT_MAX;
      output_clip_count++;
    end else if (q < OUT_MIN) begin
      q = OUT_MIN;
      output_clip_count++;
    end
    return q[OUT_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Shared state between the stimulus process, the driver and the monitor.
  // ---------------------------------------------------------------------------
  logic [ADC_BITS-1:0]      pending_codes[$];
  logic signed [OUT_W-1:0]  expected_samples[$];

  int          max_gap = 0;
  int          max_burst = 1;
  recv_style_t recv_style = RECV_STEADY;
  int          hold_off_req = 0;

  int error_count = 0;
  int sent_count = 0;
  int got_count = 0;
  int setting_count = 1;

  // ---------------------------------------------------------------------------
  // Driver. It offers the head of the pending queue in bursts of random length
  // separated by random gaps, and runs the predictor on each accepted
  // transaction. Once valid is up it stays up until the transaction is taken.
  // ---------------------------------------------------------------------------
  int gap_left = 0;
  int burst_left = 0;

  always @(posedge clk) begin
    logic next_valid;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      next_valid = in_chan.valid;
      if (in_chan.valid && in_chan.ready) begin
        expected_samples.push_back(predict_filtered_sample(in_chan.adc_code));
        void'(pending_codes.pop_front());
        sent_count++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_codes.size() != 0) begin
          next_valid = 1'b1;
          in_chan.adc_code <= pending_codes[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // A burst has ended: draw the next burst length and the pause before it.
            burst_left = $urandom_range(0, max_burst);
            gap_left = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
          end
        end
      end
      in_chan.valid <= next_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. It checks each result transaction against the oldest expected
  // sample and drives ready on a stall pattern that the current phase selects.
  // A hold-off request from the stimulus process keeps ready low for a long
  // stretch so that the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  int stall_tick = 0;
  int hold_off_seen = 0;
  int hold_off_left = 0;

  always @(posedge clk) begin
    logic                    next_ready;
    logic signed [OUT_W-1:0] want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got_count++;
        if (expected_samples.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("%0t: result transaction with nothing expected, filtered_sample %0d",
                     $realtime, out_chan.filtered_sample);
          end
        end else begin
          want = expected_samples.pop_front();
          if (out_chan.filtered_sample !== want) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("%0t: filtered_sample mismatch, expected %0d, got %0d",
                       $realtime, want, out_chan.filtered_sample);
            end
          end
        end
      end

      stall_tick++;
      if (hold_off_seen != hold_off_req) begin
        hold_off_seen++;
        hold_off_left = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        next_ready = 1'b0;
      end else begin
        case (recv_style)
          RECV_RANDOM: begin
            next_ready = ($urandom_range(0, 3) != 0);
          end
          RECV_PATTERN: begin
            // A period unlike the length of the block's program, so stalls walk
            // across every step of its work.
            next_ready = ((stall_tick % 13) >= 5);
          end
          default: begin
            next_ready = 1'b1;
          end
        endcase
      end
      out_chan.ready <= next_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic logic [ADC_BITS-1:0] clamp_code(input int v);
    if (v < 0) begin
      return '0;
    end
    if (v > CODE_MAX) begin
      return ADC_BITS'(CODE_MAX);
    end
    return ADC_BITS'(v);
  endfunction

  // Queues audio-like segments: full-range noise, square waves, triangles,
  // constant levels and quiet noise around the midpoint.
  task automatic queue_audio(input int count);
    seg_kind_t kind;
    int        len;
    int        level;
    int        amp;
    int        period;
    int        pos;
    int        tri_pos;
    while (count > 0) begin
      kind = seg_kind_t'($urandom_range(SEG_NOISE, SEG_HUM));
      len = $urandom_range(8, 48);
      if (len > count) begin
        len = count;
      end
      level = $urandom_range(0, CODE_MAX);
      amp = $urandom_range(1, MID_CODE);
      period = $urandom_range(1, 24);
      for (int k = 0; k < len; k++) begin
        case (kind)
          SEG_NOISE: begin
            pending_codes.push_back(ADC_BITS'($urandom_range(0, CODE_MAX)));
          end
          SEG_SQUARE: begin
            pending_codes.push_back(((k / period) % 2) != 0 ? clamp_code(MID_CODE + amp)
                                                             : clamp_code(MID_CODE - amp));
          end
          SEG_TRIANGLE: begin
            pos = k % (2 * period);
            tri_pos = (pos < period) ? pos : 2 * period - pos;
            pending_codes.push_back(clamp_code(MID_CODE - amp + (2 * amp * tri_pos) / period));
          end
          SEG_HOLD: begin
            pending_codes.push_back(ADC_BITS'(level));
          end
          default: begin
            pending_codes.push_back(clamp_code(MID_CODE + $urandom_range(0, 64) - 32));
          end
        endcase
      end
      count -= len;
    end
  endtask

  // Writes all six coefficients back to back, optionally followed by writes to
  // the two unused indexes, which the block must ignore. Only called while idle.
  task automatic write_coefs(input logic signed [COEF_W-1:0] vals [NUM_COEFS],
                             input bit spare_writes);
    for (int r = REG_HP_FEED; r <= REG_BP_BACK2; r++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= cfg_idx_t'(r);
      cfg_data  <= vals[r];
      @(posedge clk);
      coef[r] = vals[r];
    end
    if (spare_writes) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= IDX_SPARE_LO;
      cfg_data  <= COEF_W'($urandom);
      @(posedge clk);
      cfg_index <= IDX_SPARE_HI;
      cfg_data  <= COEF_W'($urandom);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    setting_count++;
  endtask

  // Waits until every queued code has been taken and every result has arrived,
  // then lets the block settle before anything else changes.
  task automatic wait_drained();
    while (pending_codes.size() != 0 || expected_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, a directed pass on the reset coefficients, then
  // random phases under changing coefficients and handshake styles.
  // ---------------------------------------------------------------------------
  initial begin
    logic signed [COEF_W-1:0] vals [NUM_COEFS];
    in_chan.valid = 1'b0;
    in_chan.adc_code = '0;
    out_chan.ready = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass on the reset coefficients: both code extremes (code zero
    // wraps to the most negative sample), the midpoint and its neighbours,
    // alternating bit patterns, and a full-scale square wave.
    max_gap = 3;
    max_burst = 4;
    recv_style = RECV_RANDOM;
    pending_codes.push_back(ADC_BITS'(0));
    pending_codes.push_back(ADC_BITS'(CODE_MAX));
    pending_codes.push_back(ADC_BITS'(MID_CODE));
    pending_codes.push_back(ADC_BITS'(MID_CODE - 1));
    pending_codes.push_back(ADC_BITS'(MID_CODE + 1));
    pending_codes.push_back(ADC_BITS'(1));
    pending_codes.push_back(ADC_BITS'(CODE_MAX - 1));
    pending_codes.push_back(ADC_BITS'(12'h555));
    pending_codes.push_back(ADC_BITS'(12'haaa));
    for (int k = 0; k < 10; k++) begin
      pending_codes.push_back(((k % 2) != 0) ? ADC_BITS'(CODE_MAX) : ADC_BITS'(0));
    end
    repeat (3) pending_codes.push_back(ADC_BITS'(MID_CODE));
    wait_drained();

    for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
      vals = '{RST_HP_FEED, RST_HP_BACK1, RST_HP_BACK2, RST_BP_FEED, RST_BP_BACK1, RST_BP_BACK2};
      max_gap = 15;
      max_burst = 8;
      recv_style = RECV_RANDOM;
      case (ph)
        2: begin
          // Every coefficient at its positive extreme: unstable, so both
          // stages run into 32-bit clipping.
          vals = '{default: 16'sh7fff};
          max_gap = 0;
          recv_style = RECV_STEADY;
        end
        3: begin
          vals = '{default: 16'sh8000};
          recv_style = RECV_PATTERN;
        end
        4: begin
          // The sender never pauses while the receiver holds off for a long
          // stretch, so the block fills up and pushes back on its input.
          max_gap = 0;
          hold_off_req++;
        end
        5: begin
          // Maximum feed-forward gain on the usual feedback: int16 clipping.
          vals[REG_HP_FEED] = 16'sh7fff;
          vals[REG_BP_FEED] = 16'sh7fff;
          recv_style = RECV_PATTERN;
        end
        6, 8: begin
          foreach (vals[r]) vals[r] = COEF_W'($urandom);
        end
        7: begin
          vals = '{default: 16'sh0000};
          max_gap = 0;
          recv_style = RECV_STEADY;
        end
        default: begin
        end
      endcase
      write_coefs(vals, ph == 1 || ph == 6);
      queue_audio(ITEMS_PER_PHASE);
      wait_drained();
    end

    $display("Sent %0d input transactions and checked %0d results under %0d coefficient sets.",
             sent_count, got_count, setting_count);
    $display("Predicted %0d stage clips and %0d int16 output clips.",
             stage_clip_count, output_clip_count);
    if (error_count == 0 && expected_samples.size() == 0) begin
      $display("adc_highpass_bandpass_biquad_chain_tb: clean");
    end else begin
      $display("%0d failures, %0d results still expected.", error_count,
               expected_samples.size());
      $display("adc_highpass_bandpass_biquad_chain_tb: errors");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest legal run needs.
  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d codes pending and %0d results expected.",
             pending_codes.size(), expected_samples.size());
    $display("adc_highpass_bandpass_biquad_chain_tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/abbc_pkg.sv
rtl/abbc_in_if.sv
rtl/abbc_out_if.sv
rtl/abbc_mac.sv
rtl/adc_highpass_bandpass_biquad_chain.sv
tb/adc_highpass_bandpass_biquad_chain_tb.sv
